FILE: rtl/stmp_pkg.sv
// Shared types, constants and helpers for the scrolling tilemap pixel generator.
package stmp_pkg;

  // Tile pixel store geometry
  localparam int unsigned TILE_COUNT     = 512;
  localparam int unsigned TILE_W         = $clog2(TILE_COUNT);
  localparam int unsigned TILE_PIX_AW    = TILE_W + 8;
  localparam int unsigned TILE_PIX_DEPTH = TILE_COUNT * 256;

  // Tile RAM: 1024 bytes split by address bit 4 into two 512-byte banks
  localparam int unsigned TRAM_BANK_AW    = 9;
  localparam int unsigned TRAM_BANK_DEPTH = 1 << TRAM_BANK_AW;

  // Item action codes
  localparam logic [2:0] ACT_WR_TILE  = 3'd0;
  localparam logic [2:0] ACT_RD_TILE  = 3'd1;
  localparam logic [2:0] ACT_LD_PIX   = 3'd2;
  localparam logic [2:0] ACT_LD_LUT   = 3'd3;
  localparam logic [2:0] ACT_LD_COLOR = 3'd4;
  localparam logic [2:0] ACT_RENDER   = 3'd5;

  // Result kinds
  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_PIXEL = 1'b1;

  // Config register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_X = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAL_BANK = 1'b1;
  localparam int unsigned CFG_DATA_W = 16;

  // Color resistor weights
  localparam logic [7:0] WEIGHT_B0 = 8'h0E;
  localparam logic [7:0] WEIGHT_B1 = 8'h1F;
  localparam logic [7:0] WEIGHT_B2 = 8'h43;
  localparam logic [7:0] WEIGHT_B3 = 8'h8F;

  typedef struct packed {
    logic [2:0]  action;
    logic [16:0] address;
    logic [7:0]  value;
    logic [7:0]  pixel_x;
    logic [7:0]  pixel_y;
  } stmp_in_t;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] read_data;
    logic [7:0] palette_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } stmp_out_t;

  // Tile RAM write command
  typedef struct packed {
    logic                    en;
    logic                    bank;
    logic [TRAM_BANK_AW-1:0] addr;
    logic [7:0]              data;
  } tram_wr_t;

  // Weighted sum of the four color bits; tops out at 8'hFF
  function automatic logic [7:0] weigh(input logic [3:0] nib);
    logic [7:0] v;
    v = 8'd0;
    if (nib[0]) v = v + WEIGHT_B0;
    if (nib[1]) v = v + WEIGHT_B1;
    if (nib[2]) v = v + WEIGHT_B2;
    if (nib[3]) v = v + WEIGHT_B3;
    return v;
  endfunction

endpackage

FILE: rtl/stmp_tile_ram.sv
// Banked tile RAM with a zero-fill pass after reset.
module stmp_tile_ram (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [stmp_pkg::TRAM_BANK_AW-1:0]   rd_addr_i,
  input  stmp_pkg::tram_wr_t                  wr_i,
  output logic [7:0]                          rd_lo_o,
  output logic [7:0]                          rd_hi_o,
  output logic                                busy_o
);
  import stmp_pkg::*;

  logic [7:0] bank_lo_q [TRAM_BANK_DEPTH];
  logic [7:0] bank_hi_q [TRAM_BANK_DEPTH];
  logic [7:0] rd_lo_q, rd_hi_q;

  logic                    clear_q, clear_d;
  logic [TRAM_BANK_AW-1:0] clr_cnt_q, clr_cnt_d;

  logic                    we_lo, we_hi;
  logic [TRAM_BANK_AW-1:0] wa;
  logic [7:0]              wd;

  // clear sweep owns both banks until done
  always_comb begin
    clear_d   = clear_q;
    clr_cnt_d = clr_cnt_q;
    if (clear_q) begin
      clr_cnt_d = clr_cnt_q + 1'b1;
      if (&clr_cnt_q) clear_d = 1'b0;
    end
    if (clear_q) begin
      we_lo = 1'b1;
      we_hi = 1'b1;
      wa    = clr_cnt_q;
      wd    = 8'd0;
    end else begin
      we_lo = wr_i.en && !wr_i.bank;
      we_hi = wr_i.en && wr_i.bank;
      wa    = wr_i.addr;
      wd    = wr_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_q   <= 1'b1;
      clr_cnt_q <= '0;
    end else begin
      clear_q   <= clear_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  // read-first: a read at the same edge as a write returns the old data
  always_ff @(posedge clk_i) begin
    if (we_lo) bank_lo_q[wa] <= wd;
    rd_lo_q <= bank_lo_q[rd_addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (we_hi) bank_hi_q[wa] <= wd;
    rd_hi_q <= bank_hi_q[rd_addr_i];
  end

  assign rd_lo_o = rd_lo_q;
  assign rd_hi_o = rd_hi_q;
  assign busy_o  = clear_q;

  a_no_wr_while_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear_q |-> !wr_i.en)
    else $error("tile RAM write during clear sweep");

  a_clear_ends_at_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(clear_q) |-> $past(&clr_cnt_q))
    else $error("clear sweep ended early");

  a_clear_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear_q && $past(clear_q) && $past(rst_ni) |-> clr_cnt_q == $past(clr_cnt_q) + 1'b1)
    else $error("clear counter skipped");

endmodule

FILE: rtl/scrolling_tilemap_pixel_generator.sv
// Top level: scrolled 16x16 tile background layer, five-stage memory pipeline.
// Results: an accepted read or render shows its result for one cycle, strobed by
//   res_valid_o, past stages 1-4 and the output register; writes and loads give none.
// Throughput: one transaction per cycle when not busy; results cannot be held off.
// Reset: config clears to zero; tile RAM is zero-filled, busy high until it is done.
// The other stores hold garbage until loaded.
module scrolling_tilemap_pixel_generator (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  stmp_pkg::stmp_in_t                   item_i,
  input  logic                                 cfg_we_i,
  input  logic [stmp_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [stmp_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  output logic                                 res_valid_o,
  output stmp_pkg::stmp_out_t                  result_o
);
  import stmp_pkg::*;

  // ---------------------------------------------------------------------------
  // Config registers. Only the low nine scroll bits reach the map.
  // ---------------------------------------------------------------------------
  logic [8:0] scroll_q;
  logic [1:0] bank_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scroll_q <= '0;
      bank_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SCROLL_X: scroll_q <= cfg_data_i[8:0];
        CFG_PAL_BANK: bank_q   <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: accept, scroll math, tile RAM read/write.
  // Every store is written in the same stage where it is read, so transaction
  // order holds per store without forwarding (memories are read-first).
  // ---------------------------------------------------------------------------
  logic accept, s0_res;
  logic [7:0] s0_sy;
  logic [8:0] s0_sx;
  logic [TRAM_BANK_AW-1:0] tram_ra;
  tram_wr_t tram_wr;
  logic [7:0] tram_lo, tram_hi;
  logic tram_busy;

  assign accept = start && !busy;
  assign s0_res = accept && (item_i.action == ACT_RD_TILE || item_i.action == ACT_RENDER);

  // row offset by 16 wraps mod 256; column wraps mod 512
  assign s0_sy = item_i.pixel_y + 8'd16;
  assign s0_sx = {1'b0, item_i.pixel_x} + scroll_q;

  // map cell = {col, row}; the attribute sits 16 bytes up, i.e. in the high bank
  assign tram_ra = (item_i.action == ACT_RENDER) ? {s0_sx[8:4], s0_sy[7:4]}
                                                 : {item_i.address[9:5], item_i.address[3:0]};

  assign tram_wr.en   = accept && (item_i.action == ACT_WR_TILE);
  assign tram_wr.bank = item_i.address[4];
  assign tram_wr.addr = {item_i.address[9:5], item_i.address[3:0]};
  assign tram_wr.data = item_i.value;

  stmp_tile_ram u_tram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (tram_ra),
    .wr_i      (tram_wr),
    .rd_lo_o   (tram_lo),
    .rd_hi_o   (tram_hi),
    .busy_o    (tram_busy)
  );

  assign busy = tram_busy;

  // ---------------------------------------------------------------------------
  // Stage 1: decode tile and attribute, flips, tile pixel store.
  // ---------------------------------------------------------------------------
  logic        s1_vld_q;
  logic [2:0]  s1_act_q;
  logic [16:0] s1_addr_q;
  logic [7:0]  s1_val_q;
  logic [3:0]  s1_tx_q, s1_ty_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_vld_q <= 1'b0;
    else         s1_vld_q <= accept;
  end

  always_ff @(posedge clk_i) begin
    s1_act_q  <= item_i.action;
    s1_addr_q <= item_i.address;
    s1_val_q  <= item_i.value;
    s1_tx_q   <= s0_sx[3:0];
    s1_ty_q   <= s0_sy[3:0];
  end

  logic [TILE_W-1:0]      s1_tile;
  logic [3:0]             s1_tx, s1_ty;
  logic [TILE_PIX_AW-1:0] pix_a;
  logic                   pix_we;
  logic [7:0]             s1_rdata;
  logic [2:0]             pix_mem_q [TILE_PIX_DEPTH];
  logic [2:0]             s2_pix_q;

  // attr: [7] tile bit 8, [6] y flip, [5] x flip, [4:0] color
  assign s1_tile  = {tram_hi[7], tram_lo};
  assign s1_tx    = tram_hi[5] ? ~s1_tx_q : s1_tx_q;
  assign s1_ty    = tram_hi[6] ? ~s1_ty_q : s1_ty_q;
  assign pix_a    = (s1_act_q == ACT_RENDER) ? {s1_tile, s1_ty, s1_tx}
                                              : s1_addr_q[TILE_PIX_AW-1:0];
  assign pix_we   = s1_vld_q && (s1_act_q == ACT_LD_PIX);
  assign s1_rdata = s1_addr_q[4] ? tram_hi : tram_lo;

  always_ff @(posedge clk_i) begin
    if (pix_we) pix_mem_q[pix_a] <= s1_val_q[2:0];
    s2_pix_q <= pix_mem_q[pix_a];
  end

  // ---------------------------------------------------------------------------
  // Stage 2: lookup PROM.
  // ---------------------------------------------------------------------------
  logic        s2_vld_q;
  logic [2:0]  s2_act_q;
  logic [16:0] s2_addr_q;
  logic [7:0]  s2_val_q;
  logic [4:0]  s2_color_q;
  logic [7:0]  s2_rdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_vld_q <= 1'b0;
    else         s2_vld_q <= s1_vld_q;
  end

  always_ff @(posedge clk_i) begin
    s2_act_q   <= s1_act_q;
    s2_addr_q  <= s1_addr_q;
    s2_val_q   <= s1_val_q;
    s2_color_q <= tram_hi[4:0];
    s2_rdata_q <= s1_rdata;
  end

  logic [7:0] lut_a;
  logic       lut_we;
  logic [7:0] lut_mem_q [256];
  logic [7:0] s3_lut_q;

  assign lut_a  = (s2_act_q == ACT_RENDER) ? {s2_color_q, s2_pix_q} : s2_addr_q[7:0];
  assign lut_we = s2_vld_q && (s2_act_q == ACT_LD_LUT);

  always_ff @(posedge clk_i) begin
    if (lut_we) lut_mem_q[lut_a] <= s2_val_q;
    s3_lut_q <= lut_mem_q[lut_a];
  end

  // ---------------------------------------------------------------------------
  // Stage 3: palette bank, color PROM (three planes read in parallel).
  // Plane 0 red, 1 green, 2 blue; color loads at 768 and up are dropped.
  // ---------------------------------------------------------------------------
  logic        s3_vld_q;
  logic [2:0]  s3_act_q;
  logic [16:0] s3_addr_q;
  logic [7:0]  s3_val_q;
  logic [7:0]  s3_rdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s3_vld_q <= 1'b0;
    else         s3_vld_q <= s2_vld_q;
  end

  always_ff @(posedge clk_i) begin
    s3_act_q   <= s2_act_q;
    s3_addr_q  <= s2_addr_q;
    s3_val_q   <= s2_val_q;
    s3_rdata_q <= s2_rdata_q;
  end

  logic [7:0] s3_pal;
  logic [7:0] clr_a;
  logic       clr_ld;
  logic [3:0] s4_nib_q [3];

  assign s3_pal = s3_lut_q | {2'b00, bank_q, 4'b0000};
  assign clr_a  = (s3_act_q == ACT_RENDER) ? s3_pal : s3_addr_q[7:0];
  assign clr_ld = s3_vld_q && (s3_act_q == ACT_LD_COLOR) && (s3_addr_q[16:10] == 7'd0);

  for (genvar p = 0; p < 3; p++) begin : g_plane
    logic [3:0] plane_mem_q [256];
    logic       plane_we;

    assign plane_we = clr_ld && (s3_addr_q[9:8] == 2'(p));

    always_ff @(posedge clk_i) begin
      if (plane_we) plane_mem_q[clr_a] <= s3_val_q[3:0];
      s4_nib_q[p] <= plane_mem_q[clr_a];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: resistor weighting into the output register.
  // ---------------------------------------------------------------------------
  logic       s4_vld_q;
  logic [2:0] s4_act_q;
  logic [7:0] s4_pal_q;
  logic [7:0] s4_rdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s4_vld_q <= 1'b0;
    else         s4_vld_q <= s3_vld_q;
  end

  always_ff @(posedge clk_i) begin
    s4_act_q   <= s3_act_q;
    s4_pal_q   <= s3_pal;
    s4_rdata_q <= s3_rdata_q;
  end

  logic      res_vld_q, res_vld_d;
  stmp_out_t res_q, res_d;

  always_comb begin
    res_vld_d = s4_vld_q && (s4_act_q == ACT_RD_TILE || s4_act_q == ACT_RENDER);
    res_d     = '0;
    if (s4_act_q == ACT_RENDER) begin
      res_d.result_kind   = KIND_PIXEL;
      res_d.palette_index = s4_pal_q;
      res_d.red           = weigh(s4_nib_q[0]);
      res_d.green         = weigh(s4_nib_q[1]);
      res_d.blue          = weigh(s4_nib_q[2]);
    end else begin
      res_d.result_kind   = KIND_READ;
      res_d.read_data     = s4_rdata_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) res_vld_q <= 1'b0;
    else         res_vld_q <= res_vld_d;
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = res_vld_q;
  assign result_o    = res_q;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  a_res_follows_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s0_res |-> ##5 res_valid_o)
    else $error("read/render transaction lost its result");

  a_res_has_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(s0_res, 5))
    else $error("result without a matching transaction");

  a_quiet_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !res_valid_o && !s1_vld_q)
    else $error("pipeline active during tile RAM clear");

endmodule
